/* rtl/assert_macros.svh */
// Assertion helpers; clk and arst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/dttp_pkg.sv */
package dttp_pkg;

	typedef enum logic {
		FMT_CLOCK = 1'b0,
		FMT_DATE  = 1'b1
	} fmt_t;

	localparam logic [7:0] CHAR_END   = 8'h00;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam int FIELD_NUM = 3;

	localparam logic [15:0] ACC_MAX   = 16'hFFFF;
	localparam logic [15:0] HOUR_MAX  = 16'd23;
	localparam logic [15:0] MIN_MAX   = 16'd59;
	localparam logic [15:0] MONTH_MAX = 16'd12;
	localparam logic [15:0] DAY_MAX   = 16'd31;
	localparam logic [15:0] YEAR_MIN  = 16'd1970;

	typedef struct packed {
		logic [15:0]                  acc;
		logic                         have_digit;
		logic [1:0]                   field_count;
		logic [FIELD_NUM-1:0][15:0]   field_values;
		logic                         scan_stopped;
		logic                         failed;
	} scan_state_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] first;
		logic [5:0]  second;
		logic [5:0]  third;
	} result_t;

endpackage

/* rtl/dttp_scan.sv */
module dttp_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           char_code_s1,
	input  dttp_pkg::fmt_t       fmt,
	output dttp_pkg::result_t    res
);

	dttp_pkg::scan_state_t state_q;
	dttp_pkg::scan_state_t nxt;

	logic        is_digit;
	logic        is_end;
	logic        is_close;
	logic [3:0]  digit;
	logic [19:0] prod;
	logic [15:0] acc_sat;
	logic [15:0] third_raw;

	always_comb begin
		is_digit = char_code_s1 inside {[dttp_pkg::CHAR_ZERO:dttp_pkg::CHAR_NINE]};
		is_end   = (char_code_s1 == dttp_pkg::CHAR_END);
		is_close = is_end || ((fmt == dttp_pkg::FMT_DATE) ?
			(char_code_s1 == dttp_pkg::CHAR_DASH) : (char_code_s1 == dttp_pkg::CHAR_COLON));
		digit    = 4'(char_code_s1 - dttp_pkg::CHAR_ZERO);
		// acc * 10 + digit as two shifted copies
		prod     = 20'({state_q.acc, 3'b000}) + 20'({state_q.acc, 1'b0}) + 20'(digit);
		acc_sat  = (prod > 20'(dttp_pkg::ACC_MAX)) ? dttp_pkg::ACC_MAX : prod[15:0];
	end

	always_comb begin
		nxt = state_q;
		if (fmt == dttp_pkg::FMT_CLOCK) begin
			if (!state_q.scan_stopped) begin
				if (is_digit) begin
					nxt.acc        = acc_sat;
					nxt.have_digit = 1'b1;
				end else if (is_close) begin
					// skip empty fields, drop fields past the third
					if (state_q.have_digit && state_q.field_count != 2'(dttp_pkg::FIELD_NUM)) begin
						for (int i = 0; i < dttp_pkg::FIELD_NUM; i++) begin
							if (state_q.field_count == 2'(i)) begin
								nxt.field_values[i] = state_q.acc;
							end
						end
						nxt.field_count = state_q.field_count + 2'd1;
					end
					nxt.acc        = '0;
					nxt.have_digit = 1'b0;
				end else begin
					nxt.scan_stopped = 1'b1;
				end
			end
		end else begin
			if (!state_q.failed) begin
				if (is_digit) begin
					nxt.acc        = acc_sat;
					nxt.have_digit = 1'b1;
				end else if (is_close) begin
					if (!state_q.have_digit || state_q.field_count == 2'(dttp_pkg::FIELD_NUM)) begin
						nxt.failed = 1'b1;
					end else begin
						for (int i = 0; i < dttp_pkg::FIELD_NUM; i++) begin
							if (state_q.field_count == 2'(i)) begin
								nxt.field_values[i] = state_q.acc;
							end
						end
						nxt.field_count = state_q.field_count + 2'd1;
						nxt.acc         = '0;
						nxt.have_digit  = 1'b0;
					end
				end else begin
					nxt.failed = 1'b1;
				end
			end
		end
	end

	always_comb begin
		res = '0;
		if (fmt == dttp_pkg::FMT_DATE) begin
			third_raw = nxt.field_values[2];
			res.ok = !nxt.failed && (nxt.field_count == 2'(dttp_pkg::FIELD_NUM))
				&& (nxt.field_values[1] >= 16'd1) && (nxt.field_values[1] <= dttp_pkg::MONTH_MAX)
				&& (third_raw >= 16'd1) && (third_raw <= dttp_pkg::DAY_MAX)
				&& (nxt.field_values[0] >= dttp_pkg::YEAR_MIN)
				&& (nxt.field_values[0] != dttp_pkg::ACC_MAX);
		end else begin
			// seconds default to zero when only two fields closed
			third_raw = (nxt.field_count == 2'(dttp_pkg::FIELD_NUM)) ? nxt.field_values[2] : '0;
			res.ok = (nxt.field_count >= 2'd2)
				&& (nxt.field_values[0] <= dttp_pkg::HOUR_MAX)
				&& (nxt.field_values[1] <= dttp_pkg::MIN_MAX)
				&& (third_raw <= dttp_pkg::MIN_MAX);
		end
		if (res.ok) begin
			res.first  = nxt.field_values[0];
			res.second = nxt.field_values[1][5:0];
			res.third  = third_raw[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			// the terminator clears the scan for the next string
			state_q <= is_end ? '0 : nxt;
		end
	end

endmodule

/* rtl/date_time_text_parser_unit.sv */
// Date and time text parser: takes one character per cycle on the char channel and
// returns one result per string when the terminator (code 0) is transferred. A
// character goes into an input register, the scan state and range checks sit
// between that register and the result register, so the characters of a string
// stream in back to back and its result is registered when the terminator moves
// on from the input register. The only stall is a terminator waiting
// while the result register still holds an untaken result. cfg_format selects clock
// text (0, HH:MM[:SS]) or date text (1, YYYY-MM-DD); write it only while idle.
`include "assert_macros.svh"

module date_time_text_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_format,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_code,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        valid_res,
	output logic [15:0] first_value,
	output logic [5:0]  second_value,
	output logic [5:0]  third_value
);

	dttp_pkg::fmt_t    format_q;
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              end_s1;
	logic              advance;
	logic              res_valid_q;
	dttp_pkg::result_t res_q;
	dttp_pkg::result_t scan_res;

	assign end_s1     = (char_s1 == dttp_pkg::CHAR_END);
	// hold a terminator only while the result register is full and not taken
	assign advance    = valid_s1 && (!end_s1 || !res_valid_q || res_ready);
	assign char_ready = !valid_s1 || advance;
	// hold a format write until no character or result is in flight
	assign cfg_ready  = !valid_s1 && !res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= dttp_pkg::FMT_CLOCK;
		end else if (cfg_valid && cfg_ready) begin
			format_q <= dttp_pkg::fmt_t'(cfg_format);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= char_code;
		end
	end

	dttp_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.char_code_s1 (char_s1),
		.fmt          (format_q),
		.res          (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			res_q <= scan_res;
		end
	end

	assign res_valid    = res_valid_q;
	assign valid_res    = res_q.ok;
	assign first_value  = res_q.first;
	assign second_value = res_q.second;
	assign third_value  = res_q.third;

	`ASSERT_IMPLIES(a_invalid_zero,
		res_valid_q && !res_q.ok,
		(res_q.first == 16'd0) && (res_q.second == 6'd0) && (res_q.third == 6'd0))
	`ASSERT_NEXT(a_term_held,
		valid_s1 && end_s1 && res_valid_q && !res_ready,
		valid_s1 && (char_s1 == dttp_pkg::CHAR_END))
	`ASSERT_IMPLIES(a_clock_range,
		res_valid_q && res_q.ok && (format_q == dttp_pkg::FMT_CLOCK),
		(res_q.first <= dttp_pkg::HOUR_MAX) && (res_q.second <= 6'd59)
		&& (res_q.third <= 6'd59))

endmodule

/* tb/dttp_checker.sv */
`timescale 1ns / 1ps

module dttp_checker
	import dttp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_format,
	input  logic        char_valid,
	input  logic        char_ready,
	input  logic [7:0]  char_code,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic        valid_res,
	input  logic [15:0] first_value,
	input  logic [5:0]  second_value,
	input  logic [5:0]  third_value,
	output int          err_count,
	output int          results_owed,
	output int          results_seen
);

	fmt_t        text_fmt;
	logic [15:0] acc;
	logic        have_digit;
	logic [1:0]  nfields;
	logic [15:0] field_val [FIELD_NUM];
	logic        scan_stopped;
	logic        date_failed;
	result_t     awaited_results [$];

	task automatic clear_scan();
		acc = '0;
		have_digit = 1'b0;
		nfields = '0;
		for (int i = 0; i < FIELD_NUM; i++)
			field_val[i] = '0;
		scan_stopped = 1'b0;
		date_failed = 1'b0;
	endtask

	task automatic take_digit(input logic [7:0] c);
		int unsigned sum;
		sum = 32'(acc) * 10 + 32'(c - CHAR_ZERO);
		acc = (sum > 32'(ACC_MAX)) ? ACC_MAX : sum[15:0];
		have_digit = 1'b1;
	endtask

	// Advance the scan by one character; on the terminator, queue the parse result.
	task automatic parse_char(input logic [7:0] c);
		logic        is_digit;
		logic        ok;
		logic [15:0] yr_hr;
		logic [15:0] mo_min;
		logic [15:0] day_sec;
		result_t     res;
		is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		if (text_fmt == FMT_DATE) begin
			if (!date_failed) begin
				if (is_digit) begin
					take_digit(c);
				end else if (c == CHAR_DASH || c == CHAR_END) begin
					if (!have_digit || nfields == 2'(FIELD_NUM)) begin
						date_failed = 1'b1;
					end else begin
						field_val[nfields] = acc;
						nfields = nfields + 2'd1;
						acc = '0;
						have_digit = 1'b0;
					end
				end else begin
					date_failed = 1'b1;
				end
			end
		end else if (!scan_stopped) begin
			if (is_digit) begin
				take_digit(c);
			end else if (c == CHAR_COLON || c == CHAR_END) begin
				// empty fields and fields past the third are dropped
				if (have_digit && nfields < 2'(FIELD_NUM)) begin
					field_val[nfields] = acc;
					nfields = nfields + 2'd1;
				end
				acc = '0;
				have_digit = 1'b0;
			end else begin
				scan_stopped = 1'b1;
			end
		end

		if (c == CHAR_END) begin
			yr_hr = field_val[0];
			mo_min = field_val[1];
			if (text_fmt == FMT_DATE) begin
				day_sec = field_val[2];
				ok = !date_failed && nfields == 2'd3 &&
					mo_min >= 16'd1 && mo_min <= MONTH_MAX &&
					day_sec >= 16'd1 && day_sec <= DAY_MAX &&
					yr_hr >= YEAR_MIN && yr_hr != ACC_MAX;
			end else begin
				day_sec = (nfields == 2'd3) ? field_val[2] : 16'd0;
				ok = nfields >= 2'd2 && yr_hr <= HOUR_MAX &&
					mo_min <= MIN_MAX && day_sec <= MIN_MAX;
			end
			res.ok = ok;
			res.first = ok ? yr_hr : 16'd0;
			res.second = ok ? mo_min[5:0] : 6'd0;
			res.third = ok ? day_sec[5:0] : 6'd0;
			awaited_results.push_back(res);
			clear_scan();
		end
	endtask

	task automatic check_result();
		result_t want;
		if (awaited_results.size() == 0) begin
			err_count++;
			if (err_count <= 10)
				$display("unexpected result: ok=%0d first=%0d second=%0d third=%0d",
					valid_res, first_value, second_value, third_value);
		end else begin
			want = awaited_results.pop_front();
			results_seen++;
			if (valid_res !== want.ok || first_value !== want.first ||
				second_value !== want.second || third_value !== want.third) begin
				err_count++;
				if (err_count <= 10) begin
					$display("mismatch: expected ok=%0d first=%0d second=%0d third=%0d",
						want.ok, want.first, want.second, want.third);
					$display("          actual   ok=%0d first=%0d second=%0d third=%0d",
						valid_res, first_value, second_value, third_value);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_fmt = FMT_CLOCK;
			clear_scan();
			awaited_results.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				text_fmt = fmt_t'(cfg_format);
			if (char_valid && char_ready)
				parse_char(char_code);
			if (res_valid && res_ready)
				check_result();
		end
		results_owed = awaited_results.size();
	end

endmodule

/* tb/tb_date_time_text_parser_unit.sv */
`timescale 1ns / 1ps

module tb_date_time_text_parser_unit;
	import dttp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_format;
	logic        char_valid;
	logic        char_ready;
	logic [7:0]  char_code;
	logic        res_valid;
	logic        res_ready;
	logic        valid_res;
	logic [15:0] first_value;
	logic [5:0]  second_value;
	logic [5:0]  third_value;

	int err_count;
	int results_owed;
	int results_seen;
	int cycle_count = 0;
	int chars_sent = 0;
	int strings_sent = 0;
	bit idle_on = 1'b1;

	always #1 clk = ~clk;

	date_time_text_parser_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_format   (cfg_format),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_code    (char_code),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.valid_res    (valid_res),
		.first_value  (first_value),
		.second_value (second_value),
		.third_value  (third_value)
	);

	dttp_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_format   (cfg_format),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_code    (char_code),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.valid_res    (valid_res),
		.first_value  (first_value),
		.second_value (second_value),
		.third_value  (third_value),
		.err_count    (err_count),
		.results_owed (results_owed),
		.results_seen (results_seen)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		res_ready <= idle_on ? ($urandom_range(99) >= 12) : 1'b1;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_char(input logic [7:0] c);
		if (idle_on && $urandom_range(99) < 12) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (!char_ready);
		chars_sent++;
	endtask

	task automatic send_str(input string text, input bit with_end);
		for (int i = 0; i < text.len(); i++)
			send_char(text[i]);
		if (with_end) begin
			send_char(CHAR_END);
			strings_sent++;
		end
	endtask

	// Drop valid, wait out every owed result, then let the pipeline empty.
	task automatic settle();
		char_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_format(input fmt_t f);
		cfg_valid <= 1'b1;
		cfg_format <= f;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic string clock_text();
		int    hr;
		int    mins;
		int    secs;
		string text;
		hr = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(23);
		mins = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(59);
		secs = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(59);
		if ($urandom_range(19) == 0)
			hr = $urandom_range(999999);
		text = $urandom_range(1) ? $sformatf("%02d:%02d", hr, mins)
			: $sformatf("%0d:%0d", hr, mins);
		if ($urandom_range(1))
			text = {text, $sformatf(":%02d", secs)};
		case ($urandom_range(15))
			0: text = {":", text};
			1: text = {text, ":"};
			2: text = {text, "::", $sformatf("%0d", $urandom_range(99))};
			3: text = $sformatf("%0d", hr);
			default: ;
		endcase
		return text;
	endfunction

	function automatic string date_text();
		int    yr;
		int    mon;
		int    day;
		string text;
		case ($urandom_range(9))
			0: yr = $urandom_range(1969);
			1: yr = $urandom_range(65535, 65530);
			2: yr = $urandom_range(999999, 65536);
			default: yr = $urandom_range(2099, 1970);
		endcase
		mon = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
		day = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(31, 1);
		text = $urandom_range(1) ? $sformatf("%0d-%02d-%02d", yr, mon, day)
			: $sformatf("%0d-%0d-%0d", yr, mon, day);
		case ($urandom_range(15))
			0: text = {text, "-", $sformatf("%0d", $urandom_range(31))};
			1: text = {"-", text};
			2: text = $sformatf("%0d-%0d", yr, mon);
			3: text = {text, "-"};
			default: ;
		endcase
		return text;
	endfunction

	// Mostly well-formed text; the rest is text with a stray byte or plain noise.
	task automatic gen_string(input fmt_t f);
		int    pick;
		int    pos;
		byte   stray;
		string text;
		pick = $urandom_range(99);
		if (pick < 85) begin
			text = (f == FMT_DATE) ? date_text() : clock_text();
			if (pick >= 75) begin
				pos = $urandom_range(text.len() - 1);
				stray = byte'($urandom_range(255, 1));
				text[pos] = stray;
			end
			send_str(text, 1'b1);
		end else begin
			repeat ($urandom_range(8)) send_char(8'($urandom_range(255, 1)));
			send_char(CHAR_END);
			strings_sent++;
		end
	endtask

	initial begin
		int   start_count;
		fmt_t phase_fmt;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_format = 1'b0;
		char_valid = 1'b0;
		char_code = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_format(FMT_CLOCK);
		send_str("23:59:59", 1'b1);
		send_str("24:0", 1'b1);
		send_str("::7::8:9:1", 1'b1);
		send_str("1:2x9", 1'b1);
		send_str("99999:1", 1'b1);
		// switch format in the middle of a string
		settle();
		send_str("1:2", 1'b0);
		settle();
		write_format(FMT_DATE);
		send_str("-3", 1'b1);
		send_str("1970-12-31", 1'b1);
		send_str("65535-1-1", 1'b1);
		send_str("2000--1", 1'b1);
		send_str("1-1-1-1", 1'b1);

		for (int p = 0; p < 6; p++) begin
			phase_fmt = (p % 2 == 0) ? FMT_CLOCK : FMT_DATE;
			settle();
			idle_on = (p != 3);
			write_format(phase_fmt);
			start_count = chars_sent;
			while (chars_sent - start_count < 235)
				gen_string(phase_fmt);
		end
		idle_on = 1'b1;
		settle();

		$display("Sent %0d characters in %0d clock and date strings; %0d results checked.",
			chars_sent, strings_sent, results_seen);
		$display("Covered saturation, bad fields, stray bytes and a format switch mid-string.");
		if (err_count == 0 && results_owed == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/dttp_pkg.sv
rtl/dttp_scan.sv
rtl/date_time_text_parser_unit.sv
tb/dttp_checker.sv
tb/tb_date_time_text_parser_unit.sv
